### rtl/core/assert_macros.svh
// Assertion macros shared by the rate limiter RTL.
// No dependencies; take in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge, with reset active low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a condition that must hold on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/pcwrl_pkg.sv
// Types, constants and helper functions of the per-client rate limiter.
// No dependencies; imported by every module of the block but pcwrl_ram.
package pcwrl_pkg;

    // Field widths of the request and result items
    localparam int KEY_W   = 32;
    localparam int TIME_W  = 64;
    localparam int CNT_W32 = 32;
    localparam int SLOT_W  = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS = 8'd1;
    localparam logic [TIME_W-1:0]    WINDOW_RESET   = 64'd1000000000;
    localparam logic [CNT_W32-1:0]   MAX_EV_RESET   = 32'd100;

    // Stream payload widths
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 2;

    // Request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [1:0] {
        V_ACCEPT  = 2'd0,
        V_LIMITED = 2'd1,
        V_FULL    = 2'd2,
        V_INVALID = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_CLAMP,
        BK_DIFF,
        BK_COUNT,
        BK_JUDGE,
        BK_EMIT
    } t_bk_state;

    // Request as classified by the front
    typedef struct packed {
        logic              invalid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] time_ns;
    } t_req;

    // Per-slot record held in the client table memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CNT_W32-1:0] number;
        logic [TIME_W-1:0]  start;
        logic [CNT_W32-1:0] events;
        logic [CNT_W32-1:0] rejects;
    } t_rec;

    function automatic logic [CNT_W32-1:0] sat_inc32(input logic [CNT_W32-1:0] v);
        return (v == {CNT_W32{1'b1}}) ? v : v + 32'd1;
    endfunction

endpackage

### rtl/core/pcwrl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcwrl_ram #(
    parameter int WIDTH  = 192,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/pcwrl_front.sv
// Front of the rate limiter: accepts requests, flags zero keys, queues them.
// Depends on pcwrl_pkg.
module pcwrl_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcwrl_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                            o_req_valid,
    input  logic                            i_req_ready,
    output pcwrl_pkg::t_req                 o_req
);
    import pcwrl_pkg::*;

    t_req                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                push;
    logic                pop;
    t_req                in_req;

    // Classify the incoming request
    always_comb begin
        in_req.key     = s_tdata[KEY_W-1:0];
        in_req.time_ns = s_tdata[KEY_W+TIME_W-1:KEY_W];
        in_req.invalid = (s_tdata[KEY_W-1:0] == '0);
    end

    assign s_tready    = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push        = s_tvalid && s_tready;
    assign o_req_valid = (r_count != '0);
    assign pop         = o_req_valid && i_req_ready;
    assign o_req       = r_q[r_rd_ptr];

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold queued payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_req;
        end
    end

endmodule

### rtl/core/pcwrl_back.sv
// Back of the rate limiter: slot search, window update and result register.
// Depends on pcwrl_pkg and pcwrl_ram.
module pcwrl_back #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  pcwrl_pkg::t_req                   i_req,
    input  logic [pcwrl_pkg::TIME_W-1:0]      i_window_len,
    input  logic [pcwrl_pkg::CNT_W32-1:0]     i_max_events,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcwrl_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [pcwrl_pkg::M_USER_W-1:0]    m_tuser
);
    import pcwrl_pkg::*;

    localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
    localparam int REC_W = $bits(t_rec);

    t_bk_state r_state, n_state;

    logic [MAX_CLIENTS-1:0] r_used;
    logic [CNT_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_vld;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;
    logic [CNT_W32-1:0]     r_next_number;
    logic [KEY_W-1:0]       r_key;
    logic [TIME_W-1:0]      r_time;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_diff;
    t_rec                   r_rec;
    logic [IDX_W-1:0]       r_slot;
    logic                   r_wr;
    t_verdict               r_res_verdict;
    logic [SLOT_W-1:0]      r_res_slot;
    logic [CNT_W32-1:0]     r_res_number;
    logic [CNT_W32-1:0]     r_res_count;
    logic [CNT_W32-1:0]     r_res_rejects;
    logic                   r_m_vld;
    logic [M_DATA_W-1:0]    r_m_data;
    logic [M_USER_W-1:0]    r_m_user;

    t_rec                   rd_rec;
    logic [REC_W-1:0]       rd_data;
    logic                   idx_live;
    logic                   hit;
    logic                   last;
    logic                   miss_free;
    logic                   miss_full;
    logic [IDX_W-1:0]       new_idx;
    logic                   out_free;
    logic                   out_load;
    logic                   take;
    logic                   over;
    logic [CNT_W32-1:0]     rej_inc;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    // Client table memory, one record per slot
    pcwrl_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_CLIENTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (out_load && r_wr),
        .i_wr_addr (r_slot),
        .i_wr_data (r_rec),
        .i_rd_en   (r_state == BK_SEARCH),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_rec   = t_rec'(rd_data);
    assign idx_live = (r_idx < CNT_W'(MAX_CLIENTS));
    assign hit      = r_cmp_vld && r_used[r_cmp_idx] && (rd_rec.key == r_key);
    assign last     = r_cmp_vld && (r_cmp_idx == IDX_W'(MAX_CLIENTS - 1));
    assign miss_free = last && !hit && (r_free_found || !r_used[r_cmp_idx]);
    assign miss_full = last && !hit && !(r_free_found || !r_used[r_cmp_idx]);
    assign new_idx  = r_free_found ? r_free_idx : r_cmp_idx;
    assign out_free = !r_m_vld || m_tready;
    assign over     = (r_rec.events > i_max_events);
    assign rej_inc  = sat_inc32(r_rec.rejects);
    assign slot_ext = {{SLOT_W{1'b0}}, r_slot};

    // Next state and handshake strobes
    always_comb begin
        n_state  = r_state;
        take     = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_req_valid) begin
                    take    = 1'b1;
                    n_state = i_req.invalid ? BK_EMIT : BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                if (hit || miss_free) begin
                    n_state = BK_CLAMP;
                end else if (miss_full) begin
                    n_state = BK_EMIT;
                end
            end
            BK_CLAMP: n_state = BK_DIFF;
            BK_DIFF:  n_state = BK_COUNT;
            BK_COUNT: n_state = BK_JUDGE;
            BK_JUDGE: n_state = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_req_ready = take;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control: slot occupancy, client numbering, search progress, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_next_number <= 32'd1;
            r_cmp_vld     <= 1'b0;
            r_free_found  <= 1'b0;
            r_idx         <= '0;
            r_m_vld       <= 1'b0;
        end else begin
            r_cmp_vld <= 1'b0;
            if (take) begin
                r_idx        <= '0;
                r_free_found <= 1'b0;
            end
            if (r_state == BK_SEARCH && !hit && !last) begin
                r_cmp_vld <= idx_live;
                if (idx_live) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_cmp_vld && !r_used[r_cmp_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (r_state == BK_SEARCH && miss_free) begin
                r_used[new_idx] <= 1'b1;
                r_next_number   <= sat_inc32(r_next_number);
            end
            if (out_load) begin
                r_m_vld <= 1'b1;
            end else if (m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    // Datapath: request capture, record update and result assembly
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key         <= i_req.key;
            r_time        <= i_req.time_ns;
            r_wr          <= 1'b0;
            r_res_verdict <= V_INVALID;
            r_res_slot    <= '0;
            r_res_number  <= '0;
            r_res_count   <= '0;
            r_res_rejects <= '0;
        end
        if (r_state == BK_SEARCH) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
            if (r_cmp_vld && !r_used[r_cmp_idx] && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
            if (hit) begin
                r_rec  <= rd_rec;
                r_slot <= r_cmp_idx;
            end else if (miss_free) begin
                r_rec.key     <= r_key;
                r_rec.number  <= r_next_number;
                r_rec.start   <= r_time;
                r_rec.events  <= '0;
                r_rec.rejects <= '0;
                r_slot        <= new_idx;
            end else if (miss_full) begin
                r_res_verdict <= V_FULL;
            end
        end
        // Raise an early timestamp to the window start
        if (r_state == BK_CLAMP) begin
            r_now <= (r_time < r_rec.start) ? r_rec.start : r_time;
        end
        if (r_state == BK_DIFF) begin
            r_diff <= r_now - r_rec.start;
        end
        // Restart the window once its length has passed, then count
        if (r_state == BK_COUNT) begin
            if (r_diff >= i_window_len) begin
                r_rec.start  <= r_now;
                r_rec.events <= 32'd1;
            end else begin
                r_rec.events <= sat_inc32(r_rec.events);
            end
        end
        if (r_state == BK_JUDGE) begin
            r_wr          <= 1'b1;
            r_res_verdict <= over ? V_LIMITED : V_ACCEPT;
            r_res_slot    <= slot_ext[SLOT_W-1:0];
            r_res_number  <= r_rec.number;
            r_res_count   <= r_rec.events;
            r_res_rejects <= over ? rej_inc : r_rec.rejects;
            if (over) begin
                r_rec.rejects <= rej_inc;
            end
        end
        if (out_load) begin
            r_m_user <= r_res_verdict;
            r_m_data <= {4'b0, r_res_rejects, r_res_count, r_res_number, r_res_slot};
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

endmodule

### rtl/core/per_client_window_rate_limiter.sv
// Per-client fixed-window rate limiter, a front queue feeding a search and
// update back end. An item with a zero key skips the search and update
// steps; any other item goes through the slot search, which reads one record
// a cycle from the client table memory, followed by four update steps and
// the result register. Up to four requests wait in the front queue while the
// back end works, and a finished result waits in its own register without
// holding up the next request.
// Depends on pcwrl_pkg, pcwrl_front, pcwrl_back, pcwrl_ram, assert_macros.svh.
`include "assert_macros.svh"

module per_client_window_rate_limiter #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: client_key [31:0], time_ns [95:32]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pcwrl_pkg::S_DATA_W-1:0]      s_tdata,
    // tdata: slot [3:0], client_number [35:4], window_count [67:36],
    //        rejected_total [99:68], zero [103:100]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcwrl_pkg::M_DATA_W-1:0]      m_tdata,
    // tuser: verdict [1:0]
    output logic [pcwrl_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pcwrl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcwrl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pcwrl_pkg::*;

    logic [TIME_W-1:0]  r_window_len;
    logic [CNT_W32-1:0] r_max_events;
    logic               req_valid;
    logic               req_ready;
    t_req               req;
    logic [CNT_W32-1:0] res_count;
    logic [CNT_W32-1:0] res_rejects;
    logic               res_full;
    logic               res_invalid;
    logic               res_accept;
    logic               res_limited;
    logic               count_ok;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_RESET;
            r_max_events <= MAX_EV_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LEN: r_window_len <= i_cfg_data;
                CFG_MAX_EVENTS: r_max_events <= i_cfg_data[CNT_W32-1:0];
                default: ;
            endcase
        end
    end

    pcwrl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready),
        .o_req       (req)
    );

    pcwrl_back #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .o_req_ready  (req_ready),
        .i_req        (req),
        .i_window_len (r_window_len),
        .i_max_events (r_max_events),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // Decode the pending result for the checks below
    assign res_count   = m_tdata[67:36];
    assign res_rejects = m_tdata[99:68];
    assign res_full    = m_tvalid && (m_tuser == V_FULL);
    assign res_invalid = m_tvalid && (m_tuser == V_INVALID);
    assign res_accept  = m_tvalid && (m_tuser == V_ACCEPT);
    assign res_limited = m_tvalid && (m_tuser == V_LIMITED);
    assign count_ok    = (res_count != '0) && (res_count <= r_max_events);

    // Full-table and invalid-key results carry no slot or counts
    `ASSERT_CLK(a_full_zero, i_clk, i_rst_n, res_full |-> (m_tdata == '0), "full with fields")
    `ASSERT_CLK(a_invalid_zero, i_clk, i_rst_n, res_invalid |-> (m_tdata == '0), "invalid with fields")
    // An accepted request is counted and stays within the limit
    `ASSERT_CLK(a_accept_limit, i_clk, i_rst_n, res_accept |-> count_ok, "accept over the limit")
    // A limited request has at least one rejection on record
    `ASSERT_CLK(a_limit_rejects, i_clk, i_rst_n, res_limited |-> (res_rejects != '0), "limited, no rejects")

endmodule
